### rtl/pcik_pkg.sv
package pcik_pkg;

  // Fixed widths of the item fields on the ports.
  localparam int unsigned CmdW     = 3;
  localparam int unsigned IdW      = 6;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD     = 3'd0,
    CMD_READ    = 3'd1,
    CMD_PROMOTE = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_POP     = 3'd4,
    CMD_CHECK   = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DEAD  = 2'd3
  } status_e;

  // Selects what the result register is loaded with.
  typedef enum logic [2:0] {
    RES_ZERO  = 3'd0,
    RES_ADD   = 3'd1,
    RES_FULL  = 3'd2,
    RES_EMPTY = 3'd3,
    RES_DEAD  = 3'd4,
    RES_READ  = 3'd5,
    RES_CHECK = 3'd6,
    RES_MAX   = 3'd7
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic rd_id;
    logic scan_start;
    logic scan_rd;
    logic do_add;
    logic do_promote;
    logic do_pop;
    logic res_load;
    res_e res_sel;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic id_in_range;
    logic rd_live;
    logic scan_last;
    logic out_free;
  } ctl_status_t;

endpackage

### rtl/priority_collection_increase_key_core.sv
// One command is in flight at a time. Add, unknown codes, an empty store (not for
// check_valid) and an id never handed out go from decode straight to the result; read,
// promote and check_valid of a handed-out id first look up the entry; peek_max and pop_max
// sweep the N ids handed out so far, swept one entry per cycle, before the maximum is taken.
// A stalled result delays only the next command's final step. Reset clears the controller
// state, the fill and live counts, the scan flags and the output valid only.
module priority_collection_increase_key_core #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned PAYLOAD_BITS  = 32,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcik_pkg::CmdW-1:0]     cmd_i,
  input  logic [pcik_pkg::IdW-1:0]      entry_id_i,
  input  logic [pcik_pkg::PayloadW-1:0] payload_in_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcik_pkg::StatusW-1:0]  status_o,
  output logic [pcik_pkg::IdW-1:0]      id_out_o,
  output logic [pcik_pkg::PayloadW-1:0] payload_out_o,
  output logic [pcik_pkg::PrioW-1:0]    priority_out_o,
  output logic                          is_live_o
);
  import pcik_pkg::*;

  // The controller sequences each command: it accepts a transfer only while
  // idle, decodes it against the fill and live counts, optionally reads the
  // addressed entry or sweeps all handed-out entries for the maximum, applies
  // the memory write, if any, that the command needs, and finally moves
  // the staged result into the output register once it is free. The output
  // register decouples the result channel, so the next command transfer can
  // be taken while a result is still stalled downstream. The entry memory is
  // not cleared; entries at or above the fill count are never read.
  ctl_cmd_t    ctl_cmd;
  ctl_status_t ctl_stat;

  pcik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (ctl_stat),
    .cmd_o      (ctl_cmd)
  );

  // The datapath holds the entry memory (live bit, priority and payload per
  // entry), the id counter that doubles as a fill count, the live count, the
  // running best of a maximum sweep and the result registers.
  pcik_dpath #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctl_cmd),
    .stat_o         (ctl_stat),
    .cmd_in_i       (cmd_i),
    .entry_id_i     (entry_id_i),
    .payload_in_i   (payload_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .id_out_o       (id_out_o),
    .payload_out_o  (payload_out_o),
    .priority_out_o (priority_out_o),
    .is_live_o      (is_live_o)
  );

endmodule

### rtl/pcik_ctrl.sv
module pcik_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pcik_pkg::ctl_status_t stat_i,
  output pcik_pkg::ctl_cmd_t    cmd_o
);
  import pcik_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DECODE    = 7'b0000010,
    S_LOOKUP    = 7'b0000100,
    S_SCAN      = 7'b0001000,
    S_SCAN_LAST = 7'b0010000,
    S_MAX       = 7'b0100000,
    S_EMIT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        case (stat_i.cmd)
          CMD_ADD: begin
            cmd_o.res_load = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_sel = RES_FULL;
            end else begin
              cmd_o.do_add  = 1'b1;
              cmd_o.res_sel = RES_ADD;
            end
          end
          CMD_READ, CMD_PROMOTE: begin
            if (stat_i.empty) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_EMPTY;
            end else if (!stat_i.id_in_range) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_DEAD;
            end else begin
              cmd_o.rd_id = 1'b1;
              state_d = S_LOOKUP;
            end
          end
          CMD_CHECK: begin
            if (stat_i.id_in_range) begin
              cmd_o.rd_id = 1'b1;
              state_d = S_LOOKUP;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_ZERO;
            end
          end
          CMD_PEEK, CMD_POP: begin
            if (stat_i.empty) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_EMPTY;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_ZERO;
          end
        endcase
      end
      S_LOOKUP: begin
        cmd_o.res_load = 1'b1;
        state_d = S_EMIT;
        if (stat_i.cmd == CMD_CHECK) begin
          cmd_o.res_sel = RES_CHECK;
        end else if (!stat_i.rd_live) begin
          cmd_o.res_sel = RES_DEAD;
        end else if (stat_i.cmd == CMD_READ) begin
          cmd_o.res_sel = RES_READ;
        end else begin
          cmd_o.do_promote = 1'b1;
          cmd_o.res_sel    = RES_ZERO;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_d = S_MAX;
      end
      S_MAX: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_MAX;
        cmd_o.do_pop   = (stat_i.cmd == CMD_POP);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/pcik_dpath.sv
module pcik_dpath #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned PAYLOAD_BITS  = 32,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcik_pkg::ctl_cmd_t               cmd_i,
  output pcik_pkg::ctl_status_t            stat_o,
  input  logic [pcik_pkg::CmdW-1:0]        cmd_in_i,
  input  logic [pcik_pkg::IdW-1:0]         entry_id_i,
  input  logic [pcik_pkg::PayloadW-1:0]    payload_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pcik_pkg::StatusW-1:0]     status_o,
  output logic [pcik_pkg::IdW-1:0]         id_out_o,
  output logic [pcik_pkg::PayloadW-1:0]    payload_out_o,
  output logic [pcik_pkg::PrioW-1:0]       priority_out_o,
  output logic                             is_live_o
);
  import pcik_pkg::*;

  localparam int unsigned IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW    = (CntW > IdW) ? CntW : IdW;
  localparam int unsigned PriLsb  = PAYLOAD_BITS;
  localparam int unsigned LiveBit = PAYLOAD_BITS + PRIORITY_BITS;
  localparam int unsigned EntryW  = LiveBit + 1;

  // Entry layout: live bit, priority, payload.
  logic [EntryW-1:0] mem_q [CAPACITY];

  logic [CmdW-1:0]          cmd_q;
  logic [IdW-1:0]           id_q;
  logic [PAYLOAD_BITS-1:0]  pay_in_q;
  logic [CntW-1:0]          next_free_q, next_free_d;
  logic [CntW-1:0]          live_cnt_q, live_cnt_d;
  logic [IdxW-1:0]          scan_q;
  logic                     scan_pend_q;
  logic [EntryW-1:0]        rdata_q;
  logic [IdxW-1:0]          rd_idx_q;
  logic                     found_q;
  logic [IdxW-1:0]          best_idx_q;
  logic [PRIORITY_BITS-1:0] best_pri_q;
  logic [PAYLOAD_BITS-1:0]  best_pay_q;

  logic [StatusW-1:0]       res_status_q;
  logic [IdW-1:0]           res_id_q;
  logic [PayloadW-1:0]      res_pay_q;
  logic [PrioW-1:0]         res_pri_q;
  logic                     res_live_q;

  logic                     out_valid_q, out_valid_d;
  logic [StatusW-1:0]       out_status_q;
  logic [IdW-1:0]           out_id_q;
  logic [PayloadW-1:0]      out_pay_q;
  logic [PrioW-1:0]         out_pri_q;
  logic                     out_live_q;

  logic                     rd_en, wr_en, take;
  logic [IdxW-1:0]          rd_addr, wr_addr;
  logic [EntryW-1:0]        wr_data;
  logic [PRIORITY_BITS-1:0] rd_pri, pri_inc;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic                     rd_live;

  assign rd_pri  = rdata_q[PriLsb +: PRIORITY_BITS];
  assign rd_pay  = rdata_q[PAYLOAD_BITS-1:0];
  assign rd_live = rdata_q[LiveBit];
  assign pri_inc = (rd_pri == '1) ? rd_pri : rd_pri + PRIORITY_BITS'(1);

  // Memory ports.
  assign rd_en   = cmd_i.rd_id | cmd_i.scan_rd;
  assign rd_addr = cmd_i.scan_rd ? scan_q : IdxW'(id_q);
  assign wr_en   = cmd_i.do_add | cmd_i.do_promote | cmd_i.do_pop;

  always_comb begin
    if (cmd_i.do_add) begin
      wr_addr = next_free_q[IdxW-1:0];
      wr_data = {1'b1, {PRIORITY_BITS{1'b0}}, pay_in_q};
    end else if (cmd_i.do_promote) begin
      wr_addr = IdxW'(id_q);
      wr_data = {1'b1, pri_inc, rd_pay};
    end else begin
      wr_addr = best_idx_q;
      wr_data = {1'b0, best_pri_q, best_pay_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem_q[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  // Counters: fill count and number of live entries.
  always_comb begin
    next_free_d = next_free_q;
    live_cnt_d  = live_cnt_q;
    if (cmd_i.do_add) begin
      next_free_d = next_free_q + CntW'(1);
      live_cnt_d  = live_cnt_q + CntW'(1);
    end else if (cmd_i.do_pop) begin
      live_cnt_d  = live_cnt_q - CntW'(1);
    end
  end

  // A scanned entry replaces the best one on equal priority too, so ties
  // go to the highest id.
  assign take = scan_pend_q && rd_live && (!found_q || rd_pri >= best_pri_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
      live_cnt_q  <= '0;
      scan_pend_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      next_free_q <= next_free_d;
      live_cnt_q  <= live_cnt_d;
      scan_pend_q <= cmd_i.scan_rd;
      out_valid_q <= out_valid_d;
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q    <= cmd_in_i;
      id_q     <= entry_id_i;
      pay_in_q <= PAYLOAD_BITS'(payload_in_i);
    end
    if (cmd_i.scan_start) begin
      scan_q <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_q <= scan_q + IdxW'(1);
    end
    if (take) begin
      best_idx_q <= rd_idx_q;
      best_pri_q <= rd_pri;
      best_pay_q <= rd_pay;
    end
    if (cmd_i.res_load) begin
      res_status_q <= ST_OK;
      res_id_q     <= '0;
      res_pay_q    <= '0;
      res_pri_q    <= '0;
      res_live_q   <= 1'b0;
      case (cmd_i.res_sel)
        RES_ADD: begin
          res_id_q <= IdW'(next_free_q);
        end
        RES_FULL: begin
          res_status_q <= ST_FULL;
        end
        RES_EMPTY: begin
          res_status_q <= ST_EMPTY;
        end
        RES_DEAD: begin
          res_status_q <= ST_DEAD;
        end
        RES_READ: begin
          res_pay_q <= PayloadW'(rd_pay);
          res_pri_q <= PrioW'(rd_pri);
        end
        RES_CHECK: begin
          res_live_q <= rd_live;
        end
        RES_MAX: begin
          res_id_q  <= IdW'(best_idx_q);
          res_pay_q <= PayloadW'(best_pay_q);
          res_pri_q <= PrioW'(best_pri_q);
        end
        default: begin
          res_status_q <= ST_OK;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_pay_q    <= res_pay_q;
      out_pri_q    <= res_pri_q;
      out_live_q   <= res_live_q;
    end
  end

  assign stat_o.cmd         = cmd_e'(cmd_q);
  assign stat_o.full        = (next_free_q == CntW'(CAPACITY));
  assign stat_o.empty       = (live_cnt_q == '0);
  assign stat_o.id_in_range = (CmpW'(id_q) < CmpW'(next_free_q));
  assign stat_o.rd_live     = rd_live;
  assign stat_o.scan_last   = ((CntW'(scan_q) + CntW'(1)) == next_free_q);
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign id_out_o       = out_id_q;
  assign payload_out_o  = out_pay_q;
  assign priority_out_o = out_pri_q;
  assign is_live_o      = out_live_q;

endmodule
